// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPCODE_WIDTH   = 2;
   localparam int POSITION_WIDTH = 5;
   localparam int ENTRY_WIDTH    = 32;
   localparam int LENGTH_WIDTH   = 5;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_RETRIEVE = 2'd0,
      OP_INSERT   = 2'd1,
      OP_REMOVE   = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]   opcode;
      logic [POSITION_WIDTH-1:0] position;
      logic [ENTRY_WIDTH-1:0]    entry_data;
   } req_payload_type;

   typedef struct packed {
      logic                      success;
      logic [ENTRY_WIDTH-1:0]    read_data;
      logic [LENGTH_WIDTH-1:0]   list_length;
   } rsp_payload_type;

endpackage

// ===== rtl/core/ple_ram.sv =====
module ple_ram #(
   parameter int DEPTH = ple_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = ple_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Bounded ordered list with one-based positions, held in a single-port-read, single-port-write
// memory of DEPTH entries. One transaction is worked at a time and the request side is ready
// only while the engine is idle; a finished response waits in an output register, so the next
// request may be taken before it is collected. A retrieve or any failed request goes straight to
// the finish state; an insert shifts the entries at and after its position up and then writes
// the new entry (an append writes it at once), and a remove shifts the entries after its position
// down (removing the last entry needs no shift). The shift sequencer moves one entry per cycle
// through the memory's read and write ports.
module positional_list_engine #(
   parameter int DEPTH      = ple_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ple_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ple_pkg::rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > ple_pkg::POSITION_WIDTH) ?
                           CNT_W : ple_pkg::POSITION_WIDTH) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DRAIN,
      ST_FINAL,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ple_pkg::OPCODE_WIDTH-1:0] op_ff, op_in;
   logic                     ok_ff, ok_in;
   logic [DATA_WIDTH-1:0]    data_ff, data_in;
   logic [IDX_W-1:0]         src_ff, src_in;
   logic [IDX_W-1:0]         end_ff, end_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0]    rd_data;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0]    wr_data;

   logic [CMP_W-1:0]         pos_w;
   logic [CMP_W-1:0]         n_w;
   logic                     in_range;
   logic                     ins_ok;
   logic [IDX_W-1:0]         k_idx;
   logic [IDX_W-1:0]         n_last;
   logic [63:0]              rd_wide;
   logic                     is_insert;

   assign pos_w    = CMP_W'(req_payload.position);
   assign n_w      = CMP_W'(count_ff);
   assign in_range = (pos_w != '0) && (pos_w <= n_w);
   assign ins_ok   = (pos_w != '0) && (pos_w <= n_w + CMP_W'(1)) && (n_w < CMP_W'(DEPTH));
   assign k_idx    = IDX_W'(pos_w - CMP_W'(1));
   assign n_last   = IDX_W'(n_w - CMP_W'(1));
   assign rd_wide  = 64'(rd_data);
   assign is_insert = (op_ff == ple_pkg::OP_INSERT);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      ok_in        = ok_ff;
      data_in      = data_ff;
      src_in       = src_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = src_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_payload.opcode;
               data_in  = DATA_WIDTH'(req_payload.entry_data);
               ok_in    = 1'b0;
               state_in = ST_FINISH;
               unique case (req_payload.opcode)
                  ple_pkg::OP_RETRIEVE: begin
                     if (in_range) begin
                        ok_in   = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = k_idx;
                     end
                  end
                  ple_pkg::OP_INSERT: begin
                     if (ins_ok) begin
                        ok_in    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        end_in   = k_idx;
                        src_in   = n_last;
                        if (pos_w == n_w + CMP_W'(1)) begin
                           state_in = ST_FINAL;
                        end else begin
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  ple_pkg::OP_REMOVE: begin
                     if (in_range) begin
                        ok_in    = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                        src_in   = k_idx + IDX_W'(1);
                        end_in   = n_last;
                        if (pos_w != n_w) begin
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            rd_en        = 1'b1;
            rd_addr      = src_ff;
            pend_in      = 1'b1;
            pend_addr_in = is_insert ? src_ff + IDX_W'(1) : src_ff - IDX_W'(1);
            if (src_ff == end_ff) begin
               state_in = ST_DRAIN;
            end else begin
               src_in = is_insert ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            pend_in  = 1'b0;
            state_in = is_insert ? ST_FINAL : ST_FINISH;
         end
         ST_FINAL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.success     = ok_ff;
               rsp_in.read_data   = (ok_ff && op_ff == ple_pkg::OP_RETRIEVE) ?
                                    rd_wide[ple_pkg::ENTRY_WIDTH-1:0] : '0;
               rsp_in.list_length = n_w[ple_pkg::LENGTH_WIDTH-1:0];
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      ok_ff        <= ok_in;
      data_ff      <= data_in;
      src_ff       <= src_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign wr_en   = (state_ff == ST_FINAL) || pend_ff;
   assign wr_addr = (state_ff == ST_FINAL) ? end_ff : pend_addr_ff;
   assign wr_data = (state_ff == ST_FINAL) ? data_ff : rd_data;

   ple_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("List length exceeds the storage depth.");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("Shift reads and writes the same entry in one cycle.");

   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SHIFT || state_ff == ST_DRAIN))
      else $error("Pending move outside the shift sequence.");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("Response raised without a finished transaction.");
`endif

endmodule

// ===== verif/tb_positional_list_engine.sv =====
`timescale 1ns / 1ps

module tb_positional_list_engine;

   localparam int LIST_DEPTH     = ple_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 850;
   localparam int QUIET_FIRST    = 300;
   localparam int QUIET_LAST     = 449;
   localparam int HOLDOFF_AFTER  = 60;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = LIST_DEPTH + 8;
   localparam int CYCLE_LIMIT    = 250000;
   localparam int DIRECTED_ROWS  = 15;

   localparam logic [ple_pkg::OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [ple_pkg::OPCODE_WIDTH-1:0]   opcode;
      logic [ple_pkg::POSITION_WIDTH-1:0] position;
      logic [ple_pkg::ENTRY_WIDTH-1:0]    entry_data;
      int                                 reps;
      bit                                 has_result;
      logic                               success;
      logic [ple_pkg::ENTRY_WIDTH-1:0]    read_data;
      logic [ple_pkg::LENGTH_WIDTH-1:0]   list_length;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   ple_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   ple_pkg::rsp_payload_type rsp_payload;

   logic [ple_pkg::ENTRY_WIDTH-1:0] list_mem [LIST_DEPTH];
   int                              list_count;
   ple_pkg::rsp_payload_type        list_result_q [$];

   int error_count;
   int results_seen;
   int cycle_count;
   int op_tally [4];
   int success_tally;
   int full_refusals;
   int full_reached;
   bit no_idle;
   bit holdoff_done;

   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{ple_pkg::OP_RETRIEVE, 5'd1,  32'h0000_0000, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_REMOVE,   5'd1,  32'h0000_0000, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_INSERT,   5'd0,  32'hDEAD_BEEF, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_INSERT,   5'd2,  32'h1234_5678, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_INSERT,   5'd1,  32'hFFFF_FFFF, 1,  1'b1, 1'b1, 32'h0000_0000, 5'd1},
      '{ple_pkg::OP_INSERT,   5'd1,  32'h0000_0000, 1,  1'b1, 1'b1, 32'h0000_0000, 5'd2},
      '{ple_pkg::OP_RETRIEVE, 5'd2,  32'hFFFF_FFFF, 1,  1'b1, 1'b1, 32'hFFFF_FFFF, 5'd2},
      '{OP_UNUSED,            5'd1,  32'hFFFF_FFFF, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd2},
      '{ple_pkg::OP_RETRIEVE, 5'd31, 32'h0000_0000, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd2},
      '{ple_pkg::OP_INSERT,   5'd3,  32'hA5A5_A5A5, 1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_INSERT,   5'd2,  32'h1000_0000, 13, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_INSERT,   5'd1,  32'hFFFF_FFFF, 1,  1'b1, 1'b0, 32'h0000_0000, 5'd16},
      '{ple_pkg::OP_REMOVE,   5'd16, 32'h0000_0000, 1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_REMOVE,   5'd1,  32'h0000_0000, 1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      '{ple_pkg::OP_RETRIEVE, 5'd14, 32'h0000_0000, 1,  1'b0, 1'b0, 32'h0000_0000, 5'd0}
   };

   positional_list_engine uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic ple_pkg::rsp_payload_type apply_list_request(
      input ple_pkg::req_payload_type item);
      ple_pkg::rsp_payload_type r;
      int                       p;
      int                       i;
      r = '0;
      p = item.position;
      case (item.opcode)
         ple_pkg::OP_RETRIEVE: begin
            if (p >= 1 && p <= list_count) begin
               r.success   = 1'b1;
               r.read_data = list_mem[p-1];
            end
         end
         ple_pkg::OP_INSERT: begin
            if (p >= 1 && p <= list_count + 1 && list_count < LIST_DEPTH) begin
               for (i = list_count; i > p - 1; i--) list_mem[i] = list_mem[i-1];
               list_mem[p-1] = item.entry_data;
               list_count++;
               r.success = 1'b1;
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (p >= 1 && p <= list_count) begin
               for (i = p - 1; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
               list_count--;
               list_mem[list_count] = '0;
               r.success = 1'b1;
            end
         end
         default: ;
      endcase
      r.list_length = ple_pkg::LENGTH_WIDTH'(list_count);
      return r;
   endfunction

   task automatic send_request(input ple_pkg::req_payload_type item, input bit has_result,
                               input ple_pkg::rsp_payload_type given);
      int                       gap;
      ple_pkg::rsp_payload_type predicted;
      if (!no_idle && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      op_tally[item.opcode]++;
      if (item.opcode == ple_pkg::OP_INSERT && list_count == LIST_DEPTH) full_refusals++;
      predicted = apply_list_request(item);
      if (predicted.success) success_tally++;
      if (predicted.success && item.opcode == ple_pkg::OP_INSERT && list_count == LIST_DEPTH)
         full_reached++;
      list_result_q.push_back(has_result ? given : predicted);
      @(negedge clock);
   endtask

   initial begin
      ple_pkg::rsp_payload_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (list_result_q.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = list_result_q.pop_front();
               if (rsp_payload.success !== want.success)
                  report_mismatch($sformatf("success: got %0b, want %0b",
                                            rsp_payload.success, want.success));
               if (rsp_payload.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data: got %h, want %h",
                                            rsp_payload.read_data, want.read_data));
               if (rsp_payload.list_length !== want.list_length)
                  report_mismatch($sformatf("list_length: got %0d, want %0d",
                                            rsp_payload.list_length, want.list_length));
            end
         end
      end
   end

   initial begin
      int k;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
            rsp_ready <= 1'b0;
            for (k = 0; k < HOLDOFF_CYCLES; k++) @(negedge clock);
            holdoff_done = 1'b1;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 22);
            @(negedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with transactions still outstanding.",
               cycle_count);
      $display("positional_list_engine: mismatch");
      $finish;
   end

   initial begin
      directed_row_type         row;
      ple_pkg::req_payload_type item;
      ple_pkg::rsp_payload_type given;
      int                       n;
      int                       k;
      int                       roll;
      bit                       fill_phase;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      list_count  = 0;
      for (k = 0; k < LIST_DEPTH; k++) list_mem[k] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_table[n];
         for (k = 0; k < row.reps; k++) begin
            item.opcode      = row.opcode;
            item.position    = row.position;
            item.entry_data  = row.entry_data + ple_pkg::ENTRY_WIDTH'(k);
            given.success     = row.success;
            given.read_data   = row.read_data;
            given.list_length = row.list_length;
            send_request(item, row.has_result, given);
         end
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle    = (n >= QUIET_FIRST && n <= QUIET_LAST);
         fill_phase = ((n / 120) % 2) == 0;
         roll = $urandom_range(0, 99);
         if (roll < 5)
            item.opcode = OP_UNUSED;
         else if (fill_phase)
            item.opcode = (roll < 60) ? ple_pkg::OP_INSERT :
                          (roll < 80) ? ple_pkg::OP_REMOVE : ple_pkg::OP_RETRIEVE;
         else
            item.opcode = (roll < 25) ? ple_pkg::OP_INSERT :
                          (roll < 75) ? ple_pkg::OP_REMOVE : ple_pkg::OP_RETRIEVE;
         if ($urandom_range(0, 99) < 85 &&
             (item.opcode == ple_pkg::OP_INSERT || list_count > 0)) begin
            if (item.opcode == ple_pkg::OP_INSERT)
               item.position = ple_pkg::POSITION_WIDTH'($urandom_range(1, list_count + 1));
            else
               item.position = ple_pkg::POSITION_WIDTH'($urandom_range(1, list_count));
         end else begin
            item.position = ple_pkg::POSITION_WIDTH'($urandom_range(0, 31));
         end
         item.entry_data = $urandom();
         send_request(item, 1'b0, '0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (list_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d retrieve, %0d insert, %0d remove and %0d unused-opcode requests;",
               op_tally[ple_pkg::OP_RETRIEVE], op_tally[ple_pkg::OP_INSERT],
               op_tally[ple_pkg::OP_REMOVE], op_tally[OP_UNUSED]);
      $display("%0d succeeded, the list filled %0d times, %0d inserts were refused when full.",
               success_tally, full_reached, full_refusals);
      if (error_count == 0) begin
         $display("positional_list_engine: match");
      end else begin
         $display("positional_list_engine: mismatch");
      end
      $finish;
   end

endmodule
